// ===== rtl/tbw_pkg.sv =====
`default_nettype none
package tbw_pkg;

  // Quotient bits kept by the divider: enough to see every saturation case.
  localparam int TBW_QBITS = 33;
  // Width of one weight on the result channel.
  localparam int TBW_WBITS = 32;
  // Cycles from an accepted query to its result beat.
  localparam int TBW_LAT = 43;

  // Saturation limits in quotient width and in weight width.
  localparam logic [TBW_QBITS-1:0] TBW_QPOS_MAX = 33'h0_7FFF_FFFF;
  localparam logic [TBW_QBITS-1:0] TBW_QNEG_MAX = 33'h0_8000_0000;
  localparam logic [TBW_WBITS-1:0] TBW_WPOS_SAT = 32'h7FFF_FFFF;
  localparam logic [TBW_WBITS-1:0] TBW_WNEG_SAT = 32'h8000_0000;

  // One weight leaving a weight lane.
  typedef struct packed {
    logic [TBW_WBITS-1:0] w;
    logic                 zero;
  } tbw_wres_t;

endpackage
`default_nettype wire

// ===== rtl/tbw_query_if.sv =====
`default_nettype none
interface tbw_query_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] ax;
  logic signed [CW-1:0] ay;
  logic signed [CW-1:0] az;
  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by_coord;
  logic signed [CW-1:0] bz;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] pz;

  modport source (output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                  input ready);
  modport sink (input valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz,
                output ready);
  modport monitor (input valid, ready, ax, ay, az, bx, by_coord, bz, cx, cy, cz,
                   px, py, pz);
endinterface
`default_nettype wire

// ===== rtl/tbw_result_if.sv =====
`default_nettype none
interface tbw_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] weight_a;
  logic [31:0] weight_b;
  logic [31:0] weight_c;
  logic        degenerate;

  modport source (output valid, weight_a, weight_b, weight_c, degenerate, input ready);
  modport sink (input valid, weight_a, weight_b, weight_c, degenerate, output ready);
  modport monitor (input valid, ready, weight_a, weight_b, weight_c, degenerate);
endinterface
`default_nettype wire

// ===== rtl/tbw_mul.sv =====
`default_nettype none
module tbw_mul #(
  parameter int W = 36
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [W-1:0]   a,
  input  wire logic signed [W-1:0]   b,
  output logic signed [2*W-1:0]      p
);

  localparam int LO = (W + 1) / 2;
  localparam int HI = W - LO;

  logic [W-1:0]       ma;
  logic [W-1:0]       mb;
  logic [2*LO-1:0]    p00;
  logic [LO+HI-1:0]   p01;
  logic [LO+HI-1:0]   p10;
  logic [2*HI-1:0]    p11;
  logic               sg;
  logic [2*W-1:0]     sum;

  // Magnitudes; the most negative value maps to its unsigned magnitude.
  assign ma = a[W-1] ? W'(-a) : W'(a);
  assign mb = b[W-1] ? W'(-b) : W'(b);

  // First stage: four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= ma[LO-1:0] * mb[LO-1:0];
      p01 <= ma[LO-1:0] * mb[W-1:LO];
      p10 <= ma[W-1:LO] * mb[LO-1:0];
      p11 <= ma[W-1:LO] * mb[W-1:LO];
      sg  <= a[W-1] ^ b[W-1];
    end
  end

  assign sum = (2*W)'(p00) + ((2*W)'(p01) << LO) + ((2*W)'(p10) << LO)
             + ((2*W)'(p11) << (2*LO));

  // Second stage: combine and restore the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= sg ? -$signed(sum) : $signed(sum);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tbw_weight.sv =====
`default_nettype none
module tbw_weight
  import tbw_pkg::*;
#(
  parameter int DW        = 17,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [DW-1:0] d [3],
  input  wire logic signed [DW-1:0] e [3],
  input  wire logic signed [DW-1:0] pv [3],
  output tbw_wres_t                res
);

  localparam int PW = 2 * DW + 2;          // dot product width
  localparam int MW = 2 * PW;              // wide product width
  localparam int ND = MW + 1;              // numerator and denominator
  localparam int NW = MW + 2;              // den - num
  localparam int QB = TBW_QBITS;
  localparam int RW = NW + FRAC_BITS + QB; // divider remainder

  logic signed [2*DW-1:0] pr_ee [3];
  logic signed [2*DW-1:0] pr_de [3];
  logic signed [2*DW-1:0] pr_dd [3];
  logic signed [2*DW-1:0] pr_dp [3];
  logic signed [2*DW-1:0] pr_ep [3];
  logic signed [PW-1:0]   dot_ee;
  logic signed [PW-1:0]   dot_de;
  logic signed [PW-1:0]   dot_dd;
  logic signed [PW-1:0]   dot_dp;
  logic signed [PW-1:0]   dot_ep;
  logic signed [MW-1:0]   m_ee_dp;
  logic signed [MW-1:0]   m_de_ep;
  logic signed [MW-1:0]   m_ee_dd;
  logic signed [MW-1:0]   m_de_de;
  logic signed [ND-1:0]   num;
  logic signed [ND-1:0]   den;
  logic signed [NW-1:0]   tdiff;
  logic [NW-1:0]          tmag;
  logic [ND-1:0]          dmag;
  logic                   neg6;
  logic                   zero6;
  logic [RW-1:0]          tsh;
  logic [RW-1:0]          rem [QB+1];
  logic [QB-1:0]          quo [QB+1];
  logic [ND-1:0]          dv [QB+1];
  logic                   nflag [QB+1];
  logic                   zflag [QB+1];
  logic                   bflag [QB+1];
  logic [QB-1:0]          qv;

  // Elementwise products of the five dot products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr_ee[i] <= e[i] * e[i];
        pr_de[i] <= d[i] * e[i];
        pr_dd[i] <= d[i] * d[i];
        pr_dp[i] <= d[i] * pv[i];
        pr_ep[i] <= e[i] * pv[i];
      end
    end
  end

  // Dot product sums.
  always_ff @(posedge clk) begin
    if (en) begin
      dot_ee <= PW'(pr_ee[0]) + PW'(pr_ee[1]) + PW'(pr_ee[2]);
      dot_de <= PW'(pr_de[0]) + PW'(pr_de[1]) + PW'(pr_de[2]);
      dot_dd <= PW'(pr_dd[0]) + PW'(pr_dd[1]) + PW'(pr_dd[2]);
      dot_dp <= PW'(pr_dp[0]) + PW'(pr_dp[1]) + PW'(pr_dp[2]);
      dot_ep <= PW'(pr_ep[0]) + PW'(pr_ep[1]) + PW'(pr_ep[2]);
    end
  end

  // Wide products, two stages each.
  tbw_mul #(.W(PW)) u_mul_ee_dp (.clk, .en, .a(dot_ee), .b(dot_dp), .p(m_ee_dp));
  tbw_mul #(.W(PW)) u_mul_de_ep (.clk, .en, .a(dot_de), .b(dot_ep), .p(m_de_ep));
  tbw_mul #(.W(PW)) u_mul_ee_dd (.clk, .en, .a(dot_ee), .b(dot_dd), .p(m_ee_dd));
  tbw_mul #(.W(PW)) u_mul_de_de (.clk, .en, .a(dot_de), .b(dot_de), .p(m_de_de));

  // Numerator and denominator of the projected ratio.
  always_ff @(posedge clk) begin
    if (en) begin
      num <= ND'(m_ee_dp) - ND'(m_de_ep);
      den <= ND'(m_ee_dd) - ND'(m_de_de);
    end
  end

  assign tdiff = NW'(den) - NW'(num);

  // Sign of the quotient and magnitudes of both operands.
  always_ff @(posedge clk) begin
    if (en) begin
      neg6  <= tdiff[NW-1] ^ den[ND-1];
      tmag  <= tdiff[NW-1] ? NW'(-tdiff) : NW'(tdiff);
      dmag  <= den[ND-1] ? ND'(-den) : ND'(den);
      zero6 <= (den == '0);
    end
  end

  assign tsh = RW'(tmag) << FRAC_BITS;

  // Scale the dividend; quotients that do not fit the kept bits saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]   <= tsh;
      quo[0]   <= '0;
      dv[0]    <= dmag;
      nflag[0] <= neg6;
      zflag[0] <= zero6;
      bflag[0] <= (tsh >= (RW'(dmag) << QB));
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [RW-1:0] sub;
    logic          ge;
    assign sub = RW'(dv[j]) << (QB - 1 - j);
    assign ge  = (rem[j] >= sub);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]   <= ge ? rem[j] - sub : rem[j];
        quo[j+1]   <= quo[j] | (QB'(ge) << (QB - 1 - j));
        dv[j+1]    <= dv[j];
        nflag[j+1] <= nflag[j];
        zflag[j+1] <= zflag[j];
        bflag[j+1] <= bflag[j];
      end
    end
  end

  assign qv = quo[QB];

  // Sign, saturation and the degenerate override.
  always_ff @(posedge clk) begin
    if (en) begin
      res.zero <= zflag[QB];
      if (zflag[QB]) begin
        res.w <= '0;
      end else if (!nflag[QB]) begin
        res.w <= (bflag[QB] || qv > TBW_QPOS_MAX) ? TBW_WPOS_SAT : qv[TBW_WBITS-1:0];
      end else begin
        res.w <= (bflag[QB] || qv > TBW_QNEG_MAX) ? TBW_WNEG_SAT
                                                  : TBW_WBITS'(-qv[TBW_WBITS-1:0]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/triangle_barycentric_weights_core.sv =====
// Throughput: one query per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stalled result holds every stage.
// The 33-stage restoring divider and the split wide multipliers set the depth.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
`default_nettype none
module triangle_barycentric_weights_core
  import tbw_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  tbw_query_if.sink    query,
  tbw_result_if.source result
);

  localparam int DW = COORD_BITS + 1;

  logic                  en;
  logic [TBW_LAT-1:0]    vld;
  logic signed [DW-1:0]  ab [3];
  logic signed [DW-1:0]  bc [3];
  logic signed [DW-1:0]  ca [3];
  logic signed [DW-1:0]  cb [3];
  logic signed [DW-1:0]  ac [3];
  logic signed [DW-1:0]  ap [3];
  logic signed [DW-1:0]  bp [3];
  logic signed [DW-1:0]  cp [3];
  logic signed [DW-1:0]  va [3];
  logic signed [DW-1:0]  vb [3];
  logic signed [DW-1:0]  vc [3];
  logic signed [DW-1:0]  vp [3];
  tbw_wres_t             res_a;
  tbw_wres_t             res_b;
  tbw_wres_t             res_c;
  logic                  deg;

  // Whole pipeline moves together unless the result beat is stalled.
  assign en          = !vld[TBW_LAT-1] || result.ready;
  assign query.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TBW_LAT-2:0], query.valid};
    end
  end

  assign va[0] = DW'(query.ax);
  assign va[1] = DW'(query.ay);
  assign va[2] = DW'(query.az);
  assign vb[0] = DW'(query.bx);
  assign vb[1] = DW'(query.by_coord);
  assign vb[2] = DW'(query.bz);
  assign vc[0] = DW'(query.cx);
  assign vc[1] = DW'(query.cy);
  assign vc[2] = DW'(query.cz);
  assign vp[0] = DW'(query.px);
  assign vp[1] = DW'(query.py);
  assign vp[2] = DW'(query.pz);

  // Edge and point offset vectors.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab[i] <= vb[i] - va[i];
        bc[i] <= vc[i] - vb[i];
        ca[i] <= va[i] - vc[i];
        cb[i] <= vb[i] - vc[i];
        ac[i] <= vc[i] - va[i];
        ap[i] <= vp[i] - va[i];
        bp[i] <= vp[i] - vb[i];
        cp[i] <= vp[i] - vc[i];
      end
    end
  end

  // One lane per vertex.
  tbw_weight #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_wa (
    .clk, .en, .d(ab), .e(cb), .pv(ap), .res(res_a)
  );
  tbw_weight #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_wb (
    .clk, .en, .d(bc), .e(ac), .pv(bp), .res(res_b)
  );
  tbw_weight #(.DW(DW), .FRAC_BITS(FRAC_BITS)) u_wc (
    .clk, .en, .d(ca), .e(ab), .pv(cp), .res(res_c)
  );

  assign deg = res_a.zero || res_b.zero || res_c.zero;

  // Output register; any zero denominator clears all three weights.
  always_ff @(posedge clk) begin
    if (en) begin
      result.weight_a   <= deg ? '0 : res_a.w;
      result.weight_b   <= deg ? '0 : res_b.w;
      result.weight_c   <= deg ? '0 : res_c.w;
      result.degenerate <= deg;
    end
  end

  assign result.valid = vld[TBW_LAT-1];

  // A degenerate result carries zero weights.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |->
      result.weight_a == '0 && result.weight_b == '0 && result.weight_c == '0)
    else $error("degenerate result with nonzero weight");

  // A stalled result freezes every valid bit in flight.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> $stable(vld))
    else $error("pipeline moved during a stall");

  // Reset empties the pipeline.
  assert property (@(posedge clk) rst |=> vld == '0)
    else $error("valid bits survived reset");

endmodule
`default_nettype wire
